// ----- design/dpt_pkg.sv -----
// dpt_pkg: shared constants, codes and request structs of the dirty page tracker
// used by dpt_mark_store, dpt_stack_store and dirty_page_tracker
package dpt_pkg;

    // geometry
    localparam int PAGES    = 1024;
    localparam int IDX_W    = $clog2(PAGES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int PAGE_W   = 10;
    localparam int OP_W     = 2;
    localparam int ST_W     = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // operation codes of a request
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SWAP  = 2'd1,
        OP_DRAIN = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_NEW   = 3'd0,
        ST_OLD   = 3'd1,
        ST_SWAP  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // read port of a two-sided store
    typedef struct packed {
        logic             en;
        logic             side;
        logic [IDX_W-1:0] idx;
    } rd_req_t;

    // bitmap write port
    typedef struct packed {
        logic             en;
        logic             side;
        logic [IDX_W-1:0] idx;
        logic             val;
    } mark_wr_t;

    // stack write port
    typedef struct packed {
        logic              en;
        logic              side;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] data;
    } stack_wr_t;

endpackage

// ----- design/dpt_mark_store.sv -----
// dpt_mark_store: the two page bitmaps (side a and side b) with a clearing sweep after reset
// depends on dpt_pkg
module dpt_mark_store (
    input  logic               clk,
    input  logic               rst_n,
    input  dpt_pkg::rd_req_t   rd,
    input  dpt_pkg::mark_wr_t  wr,
    output logic               rd_data,
    output logic               busy
);

    logic                     marks_a [dpt_pkg::PAGES];
    logic                     marks_b [dpt_pkg::PAGES];
    logic                     rd_data_reg;
    logic                     busy_reg;
    logic                     busy_next;
    logic [dpt_pkg::IDX_W-1:0] clr_idx_reg;
    logic [dpt_pkg::IDX_W-1:0] clr_idx_next;

    // sweep one entry of both bitmaps per cycle until the last index
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == dpt_pkg::IDX_W'(dpt_pkg::PAGES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // bitmap writes: clearing sweep or one request write
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            marks_a[clr_idx_reg] <= 1'b0;
            marks_b[clr_idx_reg] <= 1'b0;
        end
        else if (wr.en)
        begin
            if (wr.side)
            begin
                marks_b[wr.idx] <= wr.val;
            end
            else
            begin
                marks_a[wr.idx] <= wr.val;
            end
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= rd.side ? marks_b[rd.idx] : marks_a[rd.idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ----- design/dpt_stack_store.sv -----
// dpt_stack_store: the two page index stacks (side a and side b), one write and one read port
// depends on dpt_pkg
module dpt_stack_store (
    input  logic                        clk,
    input  dpt_pkg::rd_req_t            rd,
    input  dpt_pkg::stack_wr_t          wr,
    output logic [dpt_pkg::PAGE_W-1:0]  rd_data
);

    logic [dpt_pkg::PAGE_W-1:0] stack_a [dpt_pkg::PAGES];
    logic [dpt_pkg::PAGE_W-1:0] stack_b [dpt_pkg::PAGES];
    logic [dpt_pkg::PAGE_W-1:0] rd_data_reg;

    // push write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.side)
            begin
                stack_b[wr.idx] <= wr.data;
            end
            else
            begin
                stack_a[wr.idx] <= wr.data;
            end
        end
    end

    // registered top-of-stack read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= rd.side ? stack_b[rd.idx] : stack_a[rd.idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/dirty_page_tracker.sv -----
// dirty_page_tracker: double-buffered dirty page log, pipeline control and stack state
// depends on dpt_pkg, dpt_mark_store, dpt_stack_store
//
//  channel   direction  tdata fields (low bit up)            handshake
//  s_axis    in         op[1:0], page[11:2], zero pad        s_tvalid / s_tready
//  m_axis    out        status[2:0], page_out[12:3],         m_tvalid / m_tready
//                       dump_left[23:13]
//
// one request per cycle sustained while m_tready stays high; a result passes the
// input register at acceptance, then the bitmap/stack read register, then the result register
// after reset the bitmaps are swept clear with s_tready low
// a stalled result holds in the result register while two more requests can queue
// behind it; the same-cycle bitmap update of the request ahead is forwarded
module dirty_page_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpt_pkg::S_DATA_W-1:0]  s_tdata,   // op[1:0], page[11:2], zero[15:12]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpt_pkg::M_DATA_W-1:0]  m_tdata    // status[2:0], page_out[12:3], dump_left[23:13]
);

    localparam int IDX_W  = dpt_pkg::IDX_W;
    localparam int CNT_W  = dpt_pkg::CNT_W;
    localparam int PAGE_W = dpt_pkg::PAGE_W;
    localparam int OP_W   = dpt_pkg::OP_W;
    localparam int ST_W   = dpt_pkg::ST_W;

    // pipeline control
    logic a_valid_reg, b_valid_reg, out_valid_reg;
    logic out_free, b_free, a_free, b_fire, a_fire, s_accept;
    logic clearing;

    // input stage
    logic [OP_W-1:0]   a_op_reg;
    logic [PAGE_W-1:0] a_page_reg;

    // read stage
    logic [OP_W-1:0]   b_op_reg;
    logic [PAGE_W-1:0] b_page_reg;
    logic              b_fwd_reg;
    logic              b_fwd_val_reg;

    // tracker state
    logic             upd_b_reg;
    logic [CNT_W-1:0] count_a_reg, count_b_reg;

    // result register
    logic [ST_W-1:0]   out_status_reg;
    logic [PAGE_W-1:0] out_page_reg;
    logic [CNT_W-1:0]  out_left_reg;

    // commit logic
    logic              marked;
    logic [CNT_W-1:0]  cnt_upd, cnt_dmp, cnt_upd_new, cnt_dmp_new;
    logic              upd_new;
    logic [ST_W-1:0]   res_status;
    logic [PAGE_W-1:0] res_page;
    logic [CNT_W-1:0]  res_left;
    logic              upd_eff;
    logic [CNT_W-1:0]  count_a_eff, count_b_eff, cnt_dmp_eff;
    logic              fwd_hit;

    // store ports
    dpt_pkg::rd_req_t   mark_rd, stk_rd;
    dpt_pkg::mark_wr_t  mark_wr;
    dpt_pkg::stack_wr_t stk_wr;
    logic               mark_rd_data;
    logic [PAGE_W-1:0]  stk_rd_data;

    // stage handshakes
    assign out_free = !out_valid_reg || m_tready;
    assign b_fire   = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || out_free;
    assign a_fire   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free && !clearing;
    assign s_accept = s_tvalid && s_tready;

    // commit of the request in the read stage
    always_comb
    begin
        marked      = b_fwd_reg ? b_fwd_val_reg : mark_rd_data;
        cnt_upd     = upd_b_reg ? count_b_reg : count_a_reg;
        cnt_dmp     = upd_b_reg ? count_a_reg : count_b_reg;
        cnt_upd_new = cnt_upd;
        cnt_dmp_new = cnt_dmp;
        upd_new     = upd_b_reg;
        res_status  = dpt_pkg::ST_EMPTY;
        res_page    = '0;
        res_left    = cnt_dmp;
        mark_wr     = '0;
        stk_wr      = '0;
        case (b_op_reg)
            dpt_pkg::OP_WRITE:
            begin
                if (marked)
                begin
                    res_status = dpt_pkg::ST_OLD;
                end
                else
                begin
                    res_status   = dpt_pkg::ST_NEW;
                    mark_wr.en   = b_fire;
                    mark_wr.side = upd_b_reg;
                    mark_wr.idx  = b_page_reg[IDX_W-1:0];
                    mark_wr.val  = 1'b1;
                    if (cnt_upd < CNT_W'(dpt_pkg::PAGES))
                    begin
                        stk_wr.en   = b_fire;
                        stk_wr.side = upd_b_reg;
                        stk_wr.idx  = cnt_upd[IDX_W-1:0];
                        stk_wr.data = b_page_reg;
                        cnt_upd_new = cnt_upd + 1'b1;
                    end
                end
            end
            dpt_pkg::OP_SWAP:
            begin
                res_status = dpt_pkg::ST_SWAP;
                upd_new    = !upd_b_reg;
                res_left   = cnt_upd;
            end
            dpt_pkg::OP_DRAIN:
            begin
                if (cnt_dmp == '0)
                begin
                    res_left = '0;
                end
                else
                begin
                    res_status   = dpt_pkg::ST_DRAIN;
                    cnt_dmp_new  = cnt_dmp - 1'b1;
                    res_page     = stk_rd_data;
                    res_left     = cnt_dmp_new;
                    mark_wr.en   = b_fire;
                    mark_wr.side = !upd_b_reg;
                    mark_wr.idx  = stk_rd_data[IDX_W-1:0];
                    mark_wr.val  = 1'b0;
                end
            end
            default:
            begin
                res_status = dpt_pkg::ST_EMPTY;
            end
        endcase
    end

    // state as seen by the request entering the read stage
    always_comb
    begin
        upd_eff     = b_fire ? upd_new : upd_b_reg;
        count_a_eff = count_a_reg;
        count_b_eff = count_b_reg;
        if (b_fire)
        begin
            count_a_eff = upd_b_reg ? cnt_dmp_new : cnt_upd_new;
            count_b_eff = upd_b_reg ? cnt_upd_new : cnt_dmp_new;
        end
        cnt_dmp_eff = upd_eff ? count_a_eff : count_b_eff;
    end

    // store reads for the input stage request
    always_comb
    begin
        mark_rd.en   = a_fire;
        mark_rd.side = upd_eff;
        mark_rd.idx  = a_page_reg[IDX_W-1:0];
        stk_rd.en    = a_fire;
        stk_rd.side  = !upd_eff;
        stk_rd.idx   = IDX_W'(cnt_dmp_eff - 1'b1);
        fwd_hit      = mark_wr.en && (mark_wr.side == upd_eff)
                       && (mark_wr.idx == a_page_reg[IDX_W-1:0]);
    end

    dpt_mark_store u_marks (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (mark_rd),
        .wr      (mark_wr),
        .rd_data (mark_rd_data),
        .busy    (clearing)
    );

    dpt_stack_store u_stacks (
        .clk     (clk),
        .rd      (stk_rd),
        .wr      (stk_wr),
        .rd_data (stk_rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            upd_b_reg     <= 1'b0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= b_valid_reg;
            end
            upd_b_reg   <= upd_eff;
            count_a_reg <= count_a_eff;
            count_b_reg <= count_b_eff;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_op_reg   <= s_tdata[OP_W-1:0];
            a_page_reg <= s_tdata[OP_W +: PAGE_W];
        end
        if (a_fire)
        begin
            b_op_reg      <= a_op_reg;
            b_page_reg    <= a_page_reg;
            b_fwd_reg     <= fwd_hit;
            b_fwd_val_reg <= mark_wr.val;
        end
        if (b_fire)
        begin
            out_status_reg <= res_status;
            out_page_reg   <= res_page;
            out_left_reg   <= res_left;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_left_reg, out_page_reg, out_status_reg};

endmodule
